// ===== rtl/core/png_stored_deflate_encoder_top_assert.svh =====
`ifndef PNG_STORED_DEFLATE_ENCODER_TOP_ASSERT_SVH
`define PNG_STORED_DEFLATE_ENCODER_TOP_ASSERT_SVH

// Checked while out of reset.
`define PNG_SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define PNG_SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/core/png_sd_pkg.sv =====
package png_sd_pkg;

  localparam int unsigned MAX_DIM_DEF     = 4096;
  localparam int unsigned BLOCK_BYTES_DEF = 65535;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned RAW_W     = 28;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam int unsigned ADLER_MOD  = 65521;
  localparam int unsigned RESULT_CAP = 43;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             row_start;
    logic             last;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [RAW_W-1:0] raw;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_gen();
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TAB = crc_gen();

  // byte k of a big-endian word, k = 0 is the MSB
  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] k);
    return v[(5'd31 - {k, 3'b000}) -: 8];
  endfunction

endpackage

// ===== rtl/core/png_sd_if.sv =====
interface png_sd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  modport source  (output valid, op, blue, green, red, input ready);
  modport sink    (input valid, op, blue, green, red, output ready);
  modport monitor (input valid, ready, op, blue, green, red);
endinterface

interface png_sd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_end;
  modport source  (output valid, out_byte, run_last, file_end, input ready);
  modport sink    (input valid, out_byte, run_last, file_end, output ready);
  modport monitor (input valid, ready, out_byte, run_last, file_end);
endinterface

interface png_sd_cfg_if import png_sd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ===== rtl/core/png_stored_deflate_encoder_top.sv =====
// Channel | Dir | Payload                          | Request accepted when
// cfg_i   | in  | index, data (width/height)       | cfg_i.valid & cfg_i.ready
// in_i    | in  | op, blue, green, red             | in_i.valid & in_i.ready
// out_o   | out | out_byte, run_last, file_end     | out_o.valid & out_o.ready
//
// One output byte per cycle while out_o is not stalled. A pixel request
// emits 3 or 4 bytes, plus 5 per stored block header it opens; a start
// request emits 43 bytes, and the frame's last pixel adds 20.
// A two-entry queue lets the input side keep accepting while bytes drain.
// rst_ni clears all control state; width and height reset to 1.
// A stall on out_o holds the byte register; the queue then fills and
// in_i.ready drops.
`include "png_stored_deflate_encoder_top_assert.svh"

module png_stored_deflate_encoder_top import png_sd_pkg::*; #(
  parameter int unsigned MAX_DIM     = MAX_DIM_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  png_sd_cfg_if.sink   cfg_i,
  png_sd_in_if.sink    in_i,
  png_sd_out_if.source out_o
);

  push_t   push;     // classified request into the queue
  q_stat_t q_stat;
  entry_t  head;
  logic    pop;

  // front: config registers, frame tracking, drops stray pixels
  png_sd_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  png_sd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .q_stat_o (q_stat)
  );

  // back: byte sequencer with CRC-32, Adler-32 and block headers
  png_sd_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  `PNG_SD_ASSERT(a_end_is_last, out_o.valid && out_o.file_end |-> out_o.run_last, "file end without run end")
  `PNG_SD_ASSERT(a_no_push_full, push.valid |-> !q_stat.full, "push into full queue")
  `PNG_SD_ASSERT(a_no_pop_empty, pop |-> !q_stat.empty, "pop from empty queue")
  `PNG_SD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_o.valid, "output valid in reset")

endmodule

// ===== rtl/core/png_sd_front.sv =====
module png_sd_front import png_sd_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  png_sd_cfg_if.sink   cfg_i,
  png_sd_in_if.sink    in_i,
  input  q_stat_t      q_stat_i,
  output push_t        push_o
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] fw_q, fh_q, col_q, row_q;
  logic             active_q;

  logic             acc;
  logic [DIM_W-1:0] cw, ch;
  logic [DIM_W+1:0] tw;
  logic [RAW_W-1:0] raw;
  logic             col_end, row_end;

  function automatic logic [DIM_W-1:0] clamp(logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_stat_i.full;
  assign acc         = in_i.valid && in_i.ready;

  assign cw  = clamp(width_q);
  assign ch  = clamp(height_q);
  assign tw  = (DIM_W+2)'(cw) * (DIM_W+2)'(3) + (DIM_W+2)'(1);
  assign raw = RAW_W'(ch) * RAW_W'(tw);

  assign col_end = (col_q == fw_q - DIM_W'(1));
  assign row_end = (row_q == fh_q - DIM_W'(1));

  always_comb begin
    push_o.valid           = acc && (in_i.op == OP_START || active_q);
    push_o.entry.kind      = (in_i.op == OP_START) ? KIND_START : KIND_PIXEL;
    push_o.entry.row_start = (col_q == '0);
    push_o.entry.last      = col_end && row_end;
    push_o.entry.w         = cw;
    push_o.entry.h         = ch;
    push_o.entry.raw       = raw;
    push_o.entry.red       = in_i.red;
    push_o.entry.green     = in_i.green;
    push_o.entry.blue      = in_i.blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == REG_WIDTH)  width_q  <= cfg_i.data;
      if (cfg_i.index == REG_HEIGHT) height_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= DIM_W'(1);
      fh_q     <= DIM_W'(1);
      col_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b0;
    end else if (acc) begin
      if (in_i.op == OP_START) begin
        fw_q     <= cw;
        fh_q     <= ch;
        col_q    <= '0;
        row_q    <= '0;
        active_q <= 1'b1;
      end else if (active_q) begin
        if (col_end) begin
          col_q <= '0;
          if (row_end) begin
            row_q    <= '0;
            active_q <= 1'b0;
          end else begin
            row_q <= row_q + DIM_W'(1);
          end
        end else begin
          col_q <= col_q + DIM_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/png_sd_queue.sv =====
module png_sd_queue import png_sd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output entry_t  head_o,
  output q_stat_t q_stat_o
);

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o         = mem_q[rp_q];
  assign q_stat_o.full  = (cnt_q == 2'd2);
  assign q_stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.valid) wp_q <= !wp_q;
      if (pop_i)        rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i.valid) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) mem_q[wp_q] <= push_i.entry;
  end

endmodule

// ===== rtl/core/png_sd_back.sv =====
module png_sd_back import png_sd_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  entry_t       head_i,
  input  q_stat_t      q_stat_i,
  output logic         pop_o,
  png_sd_out_if.source out_o
);

  localparam int unsigned BLK_W  = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned DIV_W  = RAW_W + 1;
  localparam int unsigned DIV_SH = DIV_W + $clog2(BLOCK_BYTES);
  localparam int unsigned PROD_W = 2 * DIV_W + 1;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [DIV_W:0]   DIV_M  = DIV_M64[DIV_W:0];
  localparam logic [RAW_W-1:0] BB_RAW = RAW_W'(BLOCK_BYTES);
  localparam logic [16:0]      AMOD   = 17'(ADLER_MOD);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_RAW  = 4'b0100,
    ST_TAIL = 4'b1000
  } st_e;

  st_e              st_q;
  logic [5:0]       idx_q, cnt_q;
  logic [2:0]       hcnt_q;
  entry_t           cur_q;
  logic [31:0]      crc_q;
  logic [15:0]      ada_q, adb_q;
  logic [RAW_W-1:0] rl_q;
  logic [BLK_W-1:0] bl_q;
  logic             ovalid_q, olast_q, oend_q;
  logic [7:0]       obyte_q;

  logic [DIV_W-1:0]  div_n_q, div_qq_q;
  logic              div_busy_q, div_ph_q, zlen_ok_q;
  logic [31:0]       zlen_q;
  logic [PROD_W-1:0] div_prod;

  logic        advance, step, load;
  logic        emit_c, feed_c, crcrst_c, last_c, end_c, finish_c;
  logic        adl_c, blkld_c, tail_c;
  logic [7:0]  byte_c;
  logic [15:0] len_c;
  logic        fin_c;
  logic [31:0] crc_in, crc_nx;
  logic [16:0] sa, sb;
  logic [15:0] a_nx, b_nx;
  logic [DIV_W+3:0] zsum;

  function automatic logic [7:0] hdr_byte(logic [5:0] i, logic [31:0] w, logic [31:0] h,
                                          logic [31:0] crc, logic [31:0] zl);
    logic [7:0] b;
    case (i)
      6'd0:  b = 8'd137;
      6'd1:  b = 8'd80;
      6'd2:  b = 8'd78;
      6'd3:  b = 8'd71;
      6'd4:  b = 8'd13;
      6'd5:  b = 8'd10;
      6'd6:  b = 8'd26;
      6'd7:  b = 8'd10;
      6'd11: b = 8'd13;
      6'd12: b = "I";
      6'd13: b = "H";
      6'd14: b = "D";
      6'd15: b = "R";
      6'd16, 6'd17, 6'd18, 6'd19: b = be_byte(w, i[1:0]);
      6'd20, 6'd21, 6'd22, 6'd23: b = be_byte(h, i[1:0]);
      6'd24: b = 8'd8;
      6'd25: b = 8'd2;
      6'd29, 6'd30, 6'd31, 6'd32: b = be_byte(~crc, 2'(i - 6'd29));
      6'd33, 6'd34, 6'd35, 6'd36: b = be_byte(zl, 2'(i - 6'd33));
      6'd37: b = "I";
      6'd38: b = "D";
      6'd39: b = "A";
      6'd40: b = "T";
      6'd41: b = 8'h78;
      6'd42: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign advance = !ovalid_q || out_o.ready;

  // stored block header fields
  assign len_c = (rl_q > BB_RAW) ? 16'(BLOCK_BYTES) : 16'(rl_q);
  assign fin_c = (rl_q <= BB_RAW);

  always_comb begin
    emit_c   = 1'b0;
    feed_c   = 1'b0;
    crcrst_c = 1'b0;
    last_c   = 1'b0;
    end_c    = 1'b0;
    finish_c = 1'b0;
    adl_c    = 1'b0;
    blkld_c  = 1'b0;
    tail_c   = 1'b0;
    byte_c   = 8'h00;
    unique case (st_q)
      ST_HDR: begin
        // hold on the IDAT length until the block count is in
        emit_c   = !(idx_q >= 6'd33 && idx_q <= 6'd36 && !zlen_ok_q);
        byte_c   = hdr_byte(idx_q, 32'(cur_q.w), 32'(cur_q.h), crc_q, zlen_q);
        feed_c   = (idx_q >= 6'd12 && idx_q <= 6'd28) || idx_q >= 6'd37;
        crcrst_c = (idx_q == 6'd12) || (idx_q == 6'd37);
        last_c   = (idx_q == 6'd42);
        finish_c = last_c;
      end
      ST_RAW: begin
        emit_c = 1'b1;
        feed_c = 1'b1;
        if (bl_q == '0) begin
          case (hcnt_q)
            3'd0:    byte_c = {7'b0, fin_c};
            3'd1:    byte_c = len_c[7:0];
            3'd2:    byte_c = len_c[15:8];
            3'd3:    byte_c = ~len_c[7:0];
            default: byte_c = ~len_c[15:8];
          endcase
          blkld_c = (hcnt_q == 3'd4);
        end else begin
          case (idx_q[1:0])
            2'd0:    byte_c = 8'h00;
            2'd1:    byte_c = cur_q.red;
            2'd2:    byte_c = cur_q.green;
            default: byte_c = cur_q.blue;
          endcase
          adl_c = 1'b1;
          if (idx_q[1:0] == 2'd3) begin
            tail_c   = cur_q.last;
            finish_c = !cur_q.last;
            last_c   = !cur_q.last;
          end
        end
      end
      ST_TAIL: begin
        emit_c = 1'b1;
        case (idx_q)
          6'd0, 6'd1, 6'd2, 6'd3:     byte_c = be_byte({adb_q, ada_q}, idx_q[1:0]);
          6'd4, 6'd5, 6'd6, 6'd7:     byte_c = be_byte(~crc_q, idx_q[1:0]);
          6'd12:                      byte_c = "I";
          6'd13:                      byte_c = "E";
          6'd14:                      byte_c = "N";
          6'd15:                      byte_c = "D";
          6'd16, 6'd17, 6'd18, 6'd19: byte_c = be_byte(~crc_q, idx_q[1:0]);
          default:                    byte_c = 8'h00;
        endcase
        feed_c   = idx_q <= 6'd3 || (idx_q >= 6'd12 && idx_q <= 6'd15);
        crcrst_c = (idx_q == 6'd12);
        last_c   = (idx_q == 6'd19);
        end_c    = last_c;
        finish_c = last_c;
      end
      default: ;
    endcase
    // a pixel item is cut off after the result cap
    if (st_q != ST_HDR && emit_c && cnt_q == 6'(RESULT_CAP - 1)) begin
      last_c   = 1'b1;
      finish_c = 1'b1;
      tail_c   = 1'b0;
      end_c    = (st_q == ST_TAIL);
    end
  end

  assign crc_in = crcrst_c ? 32'hFFFF_FFFF : crc_q;
  assign crc_nx = CRC_TAB[crc_in[7:0] ^ byte_c] ^ (crc_in >> 8);

  assign sa   = 17'(ada_q) + 17'(byte_c);
  assign a_nx = (sa >= AMOD) ? 16'(sa - AMOD) : sa[15:0];
  assign sb   = 17'(adb_q) + 17'(a_nx);
  assign b_nx = (sb >= AMOD) ? 16'(sb - AMOD) : sb[15:0];

  assign step  = emit_c && advance;
  assign load  = (st_q == ST_IDLE || (finish_c && step)) && !q_stat_i.empty;
  assign pop_o = load;

  // block count = floor(n * M / 2^DIV_SH), exact for every n below 2^DIV_W
  assign div_prod = PROD_W'(div_n_q) * PROD_W'(DIV_M);
  assign zsum = (DIV_W+4)'({div_qq_q, 2'b00}) + (DIV_W+4)'(div_qq_q)
              + (DIV_W+4)'(cur_q.raw) + (DIV_W+4)'(6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      hcnt_q   <= '0;
      ovalid_q <= 1'b0;
      crc_q    <= 32'hFFFF_FFFF;
      ada_q    <= 16'd1;
      adb_q    <= 16'd0;
      rl_q     <= '0;
      bl_q     <= '0;
    end else begin
      if (step) begin
        ovalid_q <= 1'b1;
        cnt_q    <= cnt_q + 6'd1;
        if (feed_c) crc_q <= crc_nx;
        if (adl_c) begin
          ada_q <= a_nx;
          adb_q <= b_nx;
          if (rl_q != '0) rl_q <= rl_q - RAW_W'(1);
          if (bl_q != '0) bl_q <= bl_q - BLK_W'(1);
        end
        if (st_q == ST_RAW && bl_q == '0) begin
          if (blkld_c) begin
            bl_q   <= BLK_W'(len_c);
            hcnt_q <= '0;
          end else begin
            hcnt_q <= hcnt_q + 3'd1;
          end
        end else begin
          idx_q <= idx_q + 6'd1;
        end
        if (st_q == ST_HDR && idx_q == 6'd42) begin
          ada_q <= 16'd1;
          adb_q <= 16'd0;
          rl_q  <= cur_q.raw;
          bl_q  <= '0;
        end
        if (tail_c) begin
          st_q  <= ST_TAIL;
          idx_q <= '0;
        end
        if (finish_c) st_q <= ST_IDLE;
      end else if (advance) begin
        ovalid_q <= 1'b0;
      end
      if (load) begin
        cnt_q  <= '0;
        hcnt_q <= '0;
        if (head_i.kind == KIND_START) begin
          st_q  <= ST_HDR;
          idx_q <= '0;
        end else begin
          st_q  <= ST_RAW;
          idx_q <= head_i.row_start ? 6'd0 : 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_ph_q   <= 1'b0;
      zlen_ok_q  <= 1'b0;
    end else if (load && head_i.kind == KIND_START) begin
      div_busy_q <= 1'b1;
      div_ph_q   <= 1'b1;
      zlen_ok_q  <= 1'b0;
    end else if (div_busy_q) begin
      if (div_ph_q) begin
        div_ph_q <= 1'b0;
      end else begin
        div_busy_q <= 1'b0;
        zlen_ok_q  <= 1'b1;
      end
    end
  end

  // stored block count by reciprocal multiply, then the IDAT length
  always_ff @(posedge clk_i) begin
    if (load && head_i.kind == KIND_START) begin
      div_n_q <= DIV_W'(head_i.raw) + DIV_W'(BLOCK_BYTES - 1);
    end else if (div_busy_q) begin
      if (div_ph_q) begin
        div_qq_q <= DIV_W'(div_prod >> DIV_SH);
      end else begin
        zlen_q <= zsum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= head_i;
    if (step) begin
      obyte_q <= byte_c;
      olast_q <= last_c;
      oend_q  <= end_c;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.run_last = olast_q;
  assign out_o.file_end = oend_q;

endmodule

// ===== test/png_sd_checker.sv =====
module png_sd_checker import png_sd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  png_sd_cfg_if.monitor cfg_w,
  png_sd_in_if.monitor  pix_w,
  png_sd_out_if.monitor byte_w,
  output int fail_count,
  output int pending_bytes
);

  typedef struct packed {
    logic [7:0] data;
    logic       item_end;
    logic       eof;
  } png_byte_t;

  png_byte_t   byte_q[$];
  png_byte_t   item_buf[$];
  logic [31:0] crc_tab[256];
  logic [31:0] crc;
  int unsigned sum_a, sum_b, raw_left, blk_left, col, row, fw, fh;
  logic [12:0] cfg_width, cfg_height;
  bit          in_frame;

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void put(logic [7:0] b);
    png_byte_t e;
    if (item_buf.size() >= RESULT_CAP) return;
    e.data = b; e.item_end = 1'b0; e.eof = 1'b0;
    item_buf = {item_buf, e};
  endfunction

  function automatic void put_crc(logic [7:0] b);
    crc = crc_tab[crc[7:0] ^ b] ^ (crc >> 8);
    put(b);
  endfunction

  function automatic void put_word(logic [31:0] v, bit with_crc);
    for (int s = 24; s >= 0; s -= 8)
      if (with_crc) put_crc(v[s+:8]); else put(v[s+:8]);
  endfunction

  function automatic void put_tag(string t);
    for (int i = 0; i < 4; i++) put_crc(t[i]);
  endfunction

  function automatic void put_raw(logic [7:0] b);
    int unsigned len;
    if (blk_left == 0) begin
      len = raw_left > 65535 ? 65535 : raw_left;
      put_crc(raw_left <= 65535 ? 8'd1 : 8'd0);
      put_crc(len[7:0]);
      put_crc(len[15:8]);
      put_crc(~len[7:0]);
      put_crc(~len[15:8]);
      blk_left = len;
    end
    put_crc(b);
    sum_a = (sum_a + b) % ADLER_MOD;
    sum_b = (sum_b + sum_a) % ADLER_MOD;
    if (raw_left != 0) raw_left--;
    if (blk_left != 0) blk_left--;
  endfunction

  function automatic int unsigned clamp(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  function automatic void encode_item(logic op, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b);
    int unsigned raw, blocks, zlen;
    logic [7:0] sig[8];
    sig = '{137, 80, 78, 71, 13, 10, 26, 10};
    item_buf.delete();
    if (op == OP_START) begin
      fw = clamp(cfg_width);
      fh = clamp(cfg_height);
      raw = fh * (fw * 3 + 1);
      blocks = (raw + 65534) / 65535;
      zlen = 2 + blocks * 5 + raw + 4;
      foreach (sig[i]) put(sig[i]);
      put_word(32'd13, 1'b0);
      crc = '1;
      put_tag("IHDR");
      put_word(fw, 1'b1);
      put_word(fh, 1'b1);
      put_crc(8'd8); put_crc(8'd2); put_crc(8'd0); put_crc(8'd0); put_crc(8'd0);
      put_word(~crc, 1'b0);
      put_word(zlen, 1'b0);
      crc = '1;
      put_tag("IDAT");
      put_crc(8'h78); put_crc(8'h01);
      sum_a = 1; sum_b = 0; raw_left = raw; blk_left = 0;
      col = 0; row = 0; in_frame = 1;
    end else begin
      if (!in_frame) return;
      if (col == 0) put_raw(8'd0);
      put_raw(r); put_raw(g); put_raw(b);
      col++;
      if (col >= fw) begin
        col = 0;
        row++;
        if (row >= fh) begin
          put_word({sum_b[15:0], sum_a[15:0]}, 1'b1);
          put_word(~crc, 1'b0);
          put_word(32'd0, 1'b0);
          crc = '1;
          put_tag("IEND");
          put_word(~crc, 1'b0);
          item_buf[$].eof = 1'b1;
          in_frame = 0;
          row = 0;
        end
      end
    end
    if (item_buf.size() > 0) item_buf[$].item_end = 1'b1;
    byte_q = {byte_q, item_buf};
  endfunction

  initial begin
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = i;
      for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
      crc_tab[i] = c;
    end
    fail_count = 0;
    pending_bytes = 0;
    crc = '1; sum_a = 1; sum_b = 0; raw_left = 0; blk_left = 0;
    col = 0; row = 0; in_frame = 0; fw = 1; fh = 1;
    cfg_width = 1; cfg_height = 1;
  end

  always @(posedge clk_i) begin
    png_byte_t want;
    if (rst_ni) begin
      if (byte_w.valid && byte_w.ready) begin
        if (byte_q.size() == 0) begin
          report("unexpected byte", byte_w.out_byte, 8'h00);
        end else begin
          want = byte_q.pop_front();
          if (byte_w.out_byte !== want.data) report("out_byte", byte_w.out_byte, want.data);
          if (byte_w.run_last !== want.item_end)
            report("run_last", byte_w.run_last, want.item_end);
          if (byte_w.file_end !== want.eof) report("file_end", byte_w.file_end, want.eof);
        end
      end
      if (pix_w.valid && pix_w.ready)
        encode_item(pix_w.op, pix_w.red, pix_w.green, pix_w.blue);
      if (cfg_w.valid && cfg_w.ready) begin
        if (cfg_w.index == REG_WIDTH) cfg_width = cfg_w.data;
        else if (cfg_w.index == REG_HEIGHT) cfg_height = cfg_w.data;
      end
    end
    pending_bytes = byte_q.size();
  end

endmodule

// ===== test/tb_png_stored_deflate_encoder_top.sv =====
module tb_png_stored_deflate_encoder_top import png_sd_pkg::*;;

  logic clk_i, rst_ni;
  int   fail_count, pending_bytes;
  bit   calm;

  png_sd_cfg_if cfg_ch();
  png_sd_in_if  pix_ch();
  png_sd_out_if byte_ch();

  png_stored_deflate_encoder_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_ch), .in_i(pix_ch), .out_o(byte_ch)
  );

  png_sd_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_w(cfg_ch), .pix_w(pix_ch), .byte_w(byte_ch),
    .fail_count(fail_count), .pending_bytes(pending_bytes)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop; the worst run is well below this
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // sink stalls in random bursts, none in the calm tail
  initial begin
    int n;
    byte_ch.ready = 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      n = $urandom_range(1, 15);
      byte_ch.ready <= calm || ($urandom_range(0, 2) != 0);
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  // one pixel/start request; random source gap ahead of it.
  // valid stays up after acceptance so requests can follow back to back.
  task automatic send(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      pix_ch.valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    pix_ch.valid <= 1; pix_ch.op <= op;
    pix_ch.red <= r; pix_ch.green <= g; pix_ch.blue <= b;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
  endtask

  task automatic rand_pixel();
    send(OP_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
  endtask

  // let the block drain before touching registers
  task automatic settle();
    pix_ch.valid <= 0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic frame(int unsigned w, int unsigned h, int unsigned px);
    settle();
    write_reg(REG_WIDTH, DIM_W'(w));
    write_reg(REG_HEIGHT, DIM_W'(h));
    send(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
         8'($urandom_range(0, 255)));
    repeat (px) rand_pixel();
  endtask

  initial begin
    int unsigned w, h;
    calm = 0;
    rst_ni = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    pix_ch.valid = 0; pix_ch.op = 0; pix_ch.red = 0; pix_ch.green = 0; pix_ch.blue = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // pixel with no frame is dropped
    send(OP_PIXEL, 8'hff, 8'h00, 8'hff);
    // reset dims 1x1, extreme colors
    send(OP_START, 8'h00, 8'h00, 8'h00);
    send(OP_PIXEL, 8'hff, 8'hff, 8'hff);
    send(OP_PIXEL, 8'h12, 8'h34, 8'h56);  // after frame end: dropped
    // zero dims clamp to 1
    frame(0, 0, 1);
    // oversize dims clamp to max; abandoned by a new start
    frame(13'h1fff, 5000, 3);
    // start during a frame
    frame(2, 2, 2);
    send(OP_START, 8'h00, 8'h00, 8'h00);
    repeat (4) send(OP_PIXEL, 8'h00, 8'hff, 8'h00);
    // register write mid frame takes effect at next start
    frame(3, 1, 1);
    settle();
    write_reg(REG_WIDTH, DIM_W'(1));
    repeat (2) rand_pixel();
    // part of a 4096-wide row, then 1x4096 restarted with bit patterns
    frame(4096, 1, 20);
    frame(1, 4096, 0);
    send(OP_START, 8'haa, 8'h55, 8'haa);
    repeat (2) send(OP_PIXEL, 8'h55, 8'haa, 8'h55);

    // random frames, mostly small and complete
    for (int f = 0; f < 30; f++) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if (f >= 25) calm = 1;
      if ($urandom_range(0, 7) == 0) frame(w, h, $urandom_range(0, w * h - 1));
      else frame(w, h, w * h + $urandom_range(0, 1));
    end

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/png_sd_pkg.sv
rtl/core/png_sd_if.sv
rtl/core/png_sd_front.sv
rtl/core/png_sd_queue.sv
rtl/core/png_sd_back.sv
rtl/core/png_stored_deflate_encoder_top.sv
test/png_sd_checker.sv
test/tb_png_stored_deflate_encoder_top.sv
